// ===== hw/rtl/drt_pkg.sv =====
// Shared types, constants and helpers of the divider reload timer.
`timescale 1ns / 1ps

package drt_pkg;

    // Action codes of one input beat.
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;

    // Bus addresses of the timer registers.
    localparam logic [15:0] ADDR_DIVIDER = 16'hFF04;
    localparam logic [15:0] ADDR_COUNTER = 16'hFF05;
    localparam logic [15:0] ADDR_MODULO  = 16'hFF06;
    localparam logic [15:0] ADDR_CONTROL = 16'hFF07;

    localparam logic [15:0] DIVIDER_RESET = 16'hABCC;
    localparam logic [2:0]  RELOAD_DELAY  = 3'd4;
    localparam logic [3:0]  FRAME_BIT     = 4'd12;

    // Control register layout.
    localparam int CTRL_ENABLE = 2;

    // Clock select codes, named after how many ticks pass between counter steps.
    localparam logic [1:0] SEL_DIV1024 = 2'd0;
    localparam logic [1:0] SEL_DIV16   = 2'd1;
    localparam logic [1:0] SEL_DIV64   = 2'd2;
    localparam logic [1:0] SEL_DIV256  = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] address;
        logic [7:0]  write_data;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       frame_step;
        logic       timer_interrupt;
    } t_result;

    typedef struct packed {
        logic       pending;
        logic [2:0] delay;
    } t_status;

    // Divider bit watched by the counter for each clock select code.
    function automatic logic [3:0] select_bit(input logic [1:0] sel);
        logic [3:0] bit_idx;
        unique case (sel)
            SEL_DIV1024: bit_idx = 4'd9;
            SEL_DIV16:   bit_idx = 4'd3;
            SEL_DIV64:   bit_idx = 4'd5;
            SEL_DIV256:  bit_idx = 4'd7;
            default:     bit_idx = 4'd9;
        endcase
        return bit_idx;
    endfunction

endpackage

// ===== hw/rtl/drt_timer.sv =====
// Timer state registers and the single-pass update for one beat.
`timescale 1ns / 1ps

module drt_timer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  drt_pkg::t_item   i_item,
    output drt_pkg::t_result o_result,
    output drt_pkg::t_status o_status
);

    logic [15:0] r_divider, n_divider;
    logic [7:0]  r_counter, n_counter;
    logic [7:0]  r_modulo,  n_modulo;
    logic [2:0]  r_control, n_control;
    logic        r_pending, n_pending;
    logic [2:0]  r_delay,   n_delay;

    logic [15:0] div_inc;
    logic [7:0]  cnt_inc;
    logic [3:0]  sel_idx;
    logic        sel_fell;

    assign div_inc  = r_divider + 16'd1;
    assign cnt_inc  = r_counter + 8'd1;
    assign sel_idx  = drt_pkg::select_bit(r_control[1:0]);
    assign sel_fell = r_divider[sel_idx] & ~div_inc[sel_idx];

    always_comb begin
        n_divider = r_divider;
        n_counter = r_counter;
        n_modulo  = r_modulo;
        n_control = r_control;
        n_pending = r_pending;
        n_delay   = r_delay;
        o_result  = '0;
        unique case (i_item.action)
            drt_pkg::ACT_TICK: begin
                n_divider = div_inc;
                o_result.frame_step = r_divider[drt_pkg::FRAME_BIT]
                                      & ~div_inc[drt_pkg::FRAME_BIT];
                if (r_pending) begin
                    n_delay = r_delay + 3'd1;
                end
                if (r_control[drt_pkg::CTRL_ENABLE] && sel_fell) begin
                    n_counter = cnt_inc;
                    if (cnt_inc == 8'd0) begin
                        n_pending = 1'b1;
                    end
                end
                // The reload sees the delay count already advanced on this tick.
                if (n_pending && n_delay == drt_pkg::RELOAD_DELAY) begin
                    n_delay   = 3'd0;
                    n_pending = 1'b0;
                    n_counter = r_modulo;
                    o_result.timer_interrupt = 1'b1;
                end
            end
            drt_pkg::ACT_READ: begin
                priority if (i_item.address == drt_pkg::ADDR_DIVIDER) begin
                    o_result.read_data = r_divider[15:8];
                end else if (i_item.address == drt_pkg::ADDR_COUNTER) begin
                    o_result.read_data = r_counter;
                end else if (i_item.address == drt_pkg::ADDR_MODULO) begin
                    o_result.read_data = r_modulo;
                end else if (i_item.address == drt_pkg::ADDR_CONTROL) begin
                    o_result.read_data = {5'd0, r_control};
                end else begin
                    o_result.read_data = 8'd0;
                end
            end
            drt_pkg::ACT_WRITE: begin
                priority if (i_item.address == drt_pkg::ADDR_DIVIDER) begin
                    n_divider = 16'd0;
                end else if (i_item.address == drt_pkg::ADDR_COUNTER) begin
                    n_counter = i_item.write_data;
                end else if (i_item.address == drt_pkg::ADDR_MODULO) begin
                    n_modulo = i_item.write_data;
                end else if (i_item.address == drt_pkg::ADDR_CONTROL) begin
                    n_control = i_item.write_data[2:0];
                end else begin
                    n_control = r_control;
                end
            end
            default: begin
                n_divider = r_divider;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divider <= drt_pkg::DIVIDER_RESET;
            r_counter <= 8'd0;
            r_modulo  <= 8'd0;
            r_control <= 3'd0;
            r_pending <= 1'b0;
            r_delay   <= 3'd0;
        end else if (i_step) begin
            r_divider <= n_divider;
            r_counter <= n_counter;
            r_modulo  <= n_modulo;
            r_control <= n_control;
            r_pending <= n_pending;
            r_delay   <= n_delay;
        end
    end

    assign o_status.pending = r_pending;
    assign o_status.delay   = r_delay;

endmodule

// ===== hw/rtl/divider_reload_timer_top.sv =====
// Top level of the divider reload timer: input register, timer core, result register.
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+-------------------------------------------
//  in      | i_in_valid  | o_in_stall  | i_action, i_address, i_write_data
//  out     | o_out_valid | i_out_stall | o_read_data, o_frame_step, o_timer_interrupt
//
// One beat per clock is sustained while the output is not stalled; a beat's result
// passes through the input register, then the timer update into the result register.
// Synchronous active-low reset: divider to 0xABCC, timer state and valid flags cleared.
// A stall on the output holds the result register; the input register still takes one
// more beat, and the input stalls only when both registers are full.
`timescale 1ns / 1ps

module divider_reload_timer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_read_data,
    output logic        o_frame_step,
    output logic        o_timer_interrupt
);

    logic             r_in_valid;
    drt_pkg::t_item   r_item;
    logic             r_out_valid;
    drt_pkg::t_result r_result;

    drt_pkg::t_result core_result;
    drt_pkg::t_status core_status;

    logic out_free;
    logic advance;
    logic in_free;
    logic in_take;

    assign out_free = !r_out_valid || !i_out_stall;
    assign advance  = r_in_valid && out_free;
    assign in_free  = !r_in_valid || advance;
    assign in_take  = i_in_valid && in_free;

    assign o_in_stall = !in_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.action     <= i_action;
            r_item.address    <= i_address;
            r_item.write_data <= i_write_data;
        end
    end

    drt_timer u_timer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_item),
        .o_result (core_result),
        .o_status (core_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= core_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_read_data       = r_result.read_data;
    assign o_frame_step      = r_result.frame_step;
    assign o_timer_interrupt = r_result.timer_interrupt;

    // The delay count only runs while a reload is pending.
    a_delay_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !core_status.pending |-> core_status.delay == 3'd0)
        else $error("delay count nonzero with no reload pending");

    // The delay count never passes the reload point.
    a_delay_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_status.delay <= drt_pkg::RELOAD_DELAY)
        else $error("delay count beyond reload delay");

    // The latest result is a reload, so the pending state has just been cleared.
    a_reload_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_timer_interrupt |-> !core_status.pending)
        else $error("reload pending after interrupt beat");

    // Tick results never carry read data.
    a_tick_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_timer_interrupt || o_frame_step) |-> o_read_data == 8'd0)
        else $error("read data on a tick beat");

endmodule
